>>> rtl/ss_pkg.sv
// ----------------------------------------------------------------------------
// ss_pkg: shared definitions for the substring search block
// Character width and request type codes used by the block and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ss_pkg;

  localparam int CHAR_W = 8;

  // Request type carried with every input transfer
  localparam logic REQ_TEXT    = 1'b0;
  localparam logic REQ_PATTERN = 1'b1;

endpackage

`default_nettype wire

>>> rtl/ss_ram.sv
// ----------------------------------------------------------------------------
// ss_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/substring_search.sv
// ----------------------------------------------------------------------------
// substring_search: naive substring search over stored text and pattern
// Loads a text string, then a pattern string, and reports whether the
// pattern occurs as a contiguous run anywhere in the text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a character transfer happens on a rising edge with start
//   high and busy low. req_type selects text or pattern, is_last marks the
//   final character of a string. Load the text first, then the pattern.
//   Loading never stalls; characters past MAX_LEN are dropped and set the
//   overflow flag for the job.
//   After the last pattern character, busy rises and the search runs. Each
//   start position is checked by streaming text and pattern bytes out of two
//   RAMs, one compare per cycle; on a mismatch the search moves on to the
//   next start position, and a pattern longer than the text ends the search
//   with no compare at all. The first compare waits for the registered RAM
//   read data.
//   Result channel: done pulses for one cycle with found and overflow; the
//   receiver takes it in that cycle and cannot hold it off.
//   A text character after a finished job starts a new job. Characters that
//   do not fit the current phase are dropped without a result.
//   Reset clears the lengths, the flag and the phase; RAM contents are not
//   cleared, since only entries written in the current job are ever read.
//   No writes happen during the search, so reads never collide with writes.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_search #(
  parameter int MAX_LEN = 128
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      req_type,
  input  wire logic [ss_pkg::CHAR_W-1:0] char_code,
  input  wire logic                      is_last,
  output logic                           done,
  output logic                           found,
  output logic                           overflow
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam logic [LW-1:0] MAX_LEN_L = LW'(MAX_LEN);
  localparam logic [LW-1:0] ONE_L     = LW'(1);

  typedef enum logic [1:0] {
    ST_LOAD_TEXT,
    ST_LOAD_PAT,
    ST_SEARCH,
    ST_DONE
  } state_t;

  state_t state;

  // Job bookkeeping
  logic [LW-1:0] tlen;
  logic [LW-1:0] plen;
  logic          ovf;

  // Search pointers: start position and next pattern index to issue
  logic [LW-1:0] s;
  logic [LW-1:0] k;
  logic          rd_valid;   // RAM read data of an issued compare arrives
  logic          rd_last;    // that compare is the last pattern byte

  logic                      acc;
  logic                      t_we;
  logic                      p_we;
  logic [AW-1:0]             t_waddr;
  logic [AW-1:0]             t_raddr;
  logic [AW-1:0]             p_raddr;
  logic [ss_pkg::CHAR_W-1:0] t_rdata;
  logic [ss_pkg::CHAR_W-1:0] p_rdata;
  logic                      cmp_eq;
  logic [LW-1:0]             s_plus;
  logic [LW-1:0]             t_sum;
  logic [LW-1:0]             last_start;

  assign busy = (state == ST_SEARCH);
  assign acc  = start && !busy;

  // Write ports: append text/pattern at the current length, or restart at 0
  assign t_we = acc && (req_type == ss_pkg::REQ_TEXT) &&
                ((state == ST_DONE) || ((state == ST_LOAD_TEXT) && (tlen < MAX_LEN_L)));
  assign t_waddr = (state == ST_DONE) ? '0 : tlen[AW-1:0];
  assign p_we = acc && (req_type == ss_pkg::REQ_PATTERN) &&
                (state == ST_LOAD_PAT) && (plen < MAX_LEN_L);

  assign cmp_eq     = (t_rdata == p_rdata);
  assign s_plus     = s + ONE_L;
  assign t_sum      = s + k;
  assign last_start = tlen - plen;

  // Read addresses: on a mismatch restart at the next start position,
  // otherwise keep streaming the current alignment.
  always_comb begin
    if (rd_valid && !cmp_eq) begin
      t_raddr = s_plus[AW-1:0];
      p_raddr = '0;
    end else begin
      t_raddr = t_sum[AW-1:0];
      p_raddr = k[AW-1:0];
    end
  end

  ss_ram #(
    .WIDTH (ss_pkg::CHAR_W),
    .DEPTH (MAX_LEN)
  ) u_text_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (char_code),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  ss_ram #(
    .WIDTH (ss_pkg::CHAR_W),
    .DEPTH (MAX_LEN)
  ) u_pat_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (plen[AW-1:0]),
    .wdata (char_code),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD_TEXT;
      tlen     <= '0;
      plen     <= '0;
      ovf      <= 1'b0;
      done     <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_LOAD_TEXT: begin
          if (acc && (req_type == ss_pkg::REQ_TEXT)) begin
            if (tlen < MAX_LEN_L) begin
              tlen <= tlen + ONE_L;
            end else begin
              ovf <= 1'b1;
            end
            if (is_last) begin
              state <= ST_LOAD_PAT;
            end
          end
        end
        ST_LOAD_PAT: begin
          if (acc && (req_type == ss_pkg::REQ_PATTERN)) begin
            if (plen < MAX_LEN_L) begin
              plen <= plen + ONE_L;
            end else begin
              ovf <= 1'b1;
            end
            if (is_last) begin
              state    <= ST_SEARCH;
              s        <= '0;
              k        <= '0;
              rd_valid <= 1'b0;
            end
          end
        end
        ST_SEARCH: begin
          if (plen > tlen) begin
            // Pattern longer than text: never found
            done     <= 1'b1;
            found    <= 1'b0;
            overflow <= ovf;
            rd_valid <= 1'b0;
            state    <= ST_DONE;
          end else if (rd_valid && cmp_eq && rd_last) begin
            done     <= 1'b1;
            found    <= 1'b1;
            overflow <= ovf;
            rd_valid <= 1'b0;
            state    <= ST_DONE;
          end else if (rd_valid && !cmp_eq) begin
            if (s == last_start) begin
              done     <= 1'b1;
              found    <= 1'b0;
              overflow <= ovf;
              rd_valid <= 1'b0;
              state    <= ST_DONE;
            end else begin
              // Advance to the next start position; byte 0 already issued
              s        <= s_plus;
              k        <= ONE_L;
              rd_valid <= 1'b1;
              rd_last  <= (plen == ONE_L);
            end
          end else if (k < plen) begin
            k        <= k + ONE_L;
            rd_valid <= 1'b1;
            rd_last  <= ((k + ONE_L) == plen);
          end else begin
            rd_valid <= 1'b0;
          end
        end
        ST_DONE: begin
          if (acc && (req_type == ss_pkg::REQ_TEXT)) begin
            // New job: this character lands at entry 0
            tlen  <= ONE_L;
            plen  <= '0;
            ovf   <= 1'b0;
            state <= is_last ? ST_LOAD_PAT : ST_LOAD_TEXT;
          end
        end
        default: begin
          state <= ST_LOAD_TEXT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/ss_check.sv
// ----------------------------------------------------------------------------
// ss_check: port-level checker for the substring search block
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ss_check (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      req_type,
  input wire logic                      is_last,
  input wire logic                      done,
  input wire logic                      found,
  input wire logic                      overflow
);

  // A result always closes a search that was running
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a preceding search");

  // The block is free again while the result is shown
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy while result is shown");

  // A result strobe is never followed directly by another
  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("repeated result");

  // A search starts only after the last pattern character is taken
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && (req_type == ss_pkg::REQ_PATTERN) && is_last))
    else $error("search started without a final pattern transfer");

  // Result fields carry known values while the strobe is up
  a_result_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown({found, overflow}))
    else $error("unknown result fields");

endmodule

bind substring_search ss_check u_ss_check (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .req_type  (req_type),
  .is_last   (is_last),
  .done      (done),
  .found     (found),
  .overflow  (overflow)
);

`default_nettype wire

>>> bench/substring_search_tb.sv
// ----------------------------------------------------------------------------
// substring_search_tb: self-checking bench for the substring search block
// Streams text and pattern strings into the block, predicts each found and
// overflow verdict with a scoreboard of its own, and checks every result
// strobe against the oldest pending verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_search_tb;

  localparam int CHAR_W       = ss_pkg::CHAR_W;
  localparam int MAX_LEN      = 128;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int IDLE_PCT     = 28;
  localparam int NOISE_PCT    = 5;
  localparam int JOB_ITEMS    = 700;
  localparam int MIN_JOBS     = 40;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {LOAD_TEXT, LOAD_PATTERN, JOB_DONE} job_phase_t;

  typedef struct packed {
    logic found;
    logic overflow;
  } verdict_t;

  // Scoreboard: mirrors the job state, queues one verdict per finished job.
  class match_scoreboard;
    logic [CHAR_W-1:0] text_mem [MAX_LEN];
    logic [CHAR_W-1:0] pat_mem [MAX_LEN];
    int                text_len;
    int                pat_len;
    logic              trunc_seen;
    job_phase_t        phase;
    verdict_t          verdicts [$];
    int                errors;

    function new();
      text_len   = 0;
      pat_len    = 0;
      trunc_seen = 1'b0;
      phase      = LOAD_TEXT;
      errors     = 0;
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    // Try every start position of the stored text.
    function logic pattern_in_text();
      int   s;
      int   k;
      logic hit;
      if (pat_len > text_len) return 1'b0;
      for (s = 0; s + pat_len <= text_len; s++) begin
        hit = 1'b1;
        for (k = 0; k < pat_len; k++) begin
          if (text_mem[s + k] != pat_mem[k]) hit = 1'b0;
        end
        if (hit) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_char(logic req, logic [CHAR_W-1:0] c, logic last);
      verdict_t v;
      if (req == ss_pkg::REQ_TEXT) begin
        // a text character after a finished job opens a new one
        if (phase == JOB_DONE) begin
          text_len   = 0;
          pat_len    = 0;
          trunc_seen = 1'b0;
          phase      = LOAD_TEXT;
        end
        if (phase != LOAD_TEXT) return;
        if (text_len < MAX_LEN) begin
          text_mem[text_len] = c;
          text_len++;
        end else begin
          trunc_seen = 1'b1;
        end
        if (last) phase = LOAD_PATTERN;
        return;
      end
      if (phase != LOAD_PATTERN) return;
      if (pat_len < MAX_LEN) begin
        pat_mem[pat_len] = c;
        pat_len++;
      end else begin
        trunc_seen = 1'b1;
      end
      if (!last) return;
      phase      = JOB_DONE;
      v.found    = pattern_in_text();
      v.overflow = trunc_seen;
      verdicts.push_back(v);
    endfunction

    function void check_result(logic f, logic o);
      verdict_t v;
      if (verdicts.size() == 0) begin
        $error("result with no pending verdict: found %0b, overflow %0b", f, o);
        errors++;
        return;
      end
      v = verdicts.pop_front();
      if (f !== v.found) begin
        $error("found mismatch: expected %0b, actual %0b", v.found, f);
        errors++;
      end
      if (o !== v.overflow) begin
        $error("overflow mismatch: expected %0b, actual %0b", v.overflow, o);
        errors++;
      end
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  logic              req_type  = ss_pkg::REQ_TEXT;
  logic [CHAR_W-1:0] char_code = '0;
  logic              is_last   = 1'b0;
  logic              busy;
  logic              done;
  logic              found;
  logic              overflow;

  match_scoreboard   sb = new();
  int                cycles     = 0;
  int                items_sent = 0;
  bit                idle_on    = 1'b1;
  logic [CHAR_W-1:0] chars [$];

  substring_search #(
    .MAX_LEN(MAX_LEN)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .char_code(char_code),
    .is_last  (is_last),
    .done     (done),
    .found    (found),
    .overflow (overflow)
  );

  always #4 clk = ~clk;

  // Hard stop: a hung search or a lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The receiver cannot stall, so take every strobe as it comes.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(found, overflow);
  end

  // Narrow alphabet makes matches likely; wide covers every byte value,
  // the zero character included.
  function automatic logic [CHAR_W-1:0] pick_char(bit wide);
    if (wide) return CHAR_W'($urandom_range(0, 255));
    return CHAR_W'(8'h61 + $urandom_range(0, 2));
  endfunction

  // Drive one character and hold it until the block takes the transfer.
  // Inputs and busy are read right after the edge, before any update lands.
  task automatic send_char(logic req, logic [CHAR_W-1:0] c, logic last);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    req_type  <= req;
    char_code <= c;
    is_last   <= last;
    do @(posedge clk); while (busy);
    sb.note_char(req, c, last);
  endtask

  // Send a whole string, last character marked. With noise on, slip in
  // characters of the other kind; the current phase drops them.
  task automatic send_string(logic req, logic [CHAR_W-1:0] s [$], bit noisy);
    int   i;
    logic other;
    other = (req == ss_pkg::REQ_TEXT) ? ss_pkg::REQ_PATTERN : ss_pkg::REQ_TEXT;
    for (i = 0; i < s.size(); i++) begin
      if (noisy && $urandom_range(0, 99) < NOISE_PCT)
        send_char(other, pick_char(1'b1), 1'($urandom_range(0, 1)));
      send_char(req, s[i], i == s.size() - 1);
    end
  endtask

  // Drop start and hold off until every pending verdict has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // One full job: random text, then a pattern that is either cut from the
  // text (maybe with one character changed) or random.
  task automatic run_job(int tlen, int plen, bit wide);
    logic [CHAR_W-1:0] txt [$];
    logic [CHAR_W-1:0] pat [$];
    int                ofs;
    int                i;
    for (i = 0; i < tlen; i++) txt.push_back(pick_char(wide));
    if (plen <= tlen && $urandom_range(0, 1) == 1) begin
      ofs = $urandom_range(0, tlen - plen);
      for (i = 0; i < plen; i++) pat.push_back(txt[ofs + i]);
      if ($urandom_range(0, 3) == 0) pat[$urandom_range(0, plen - 1)] = pick_char(wide);
    end else begin
      for (i = 0; i < plen; i++) pat.push_back(pick_char(wide));
    end
    send_string(ss_pkg::REQ_TEXT, txt, 1'b1);
    send_string(ss_pkg::REQ_PATTERN, pat, 1'b1);
    // a pattern character after the job is done must be dropped
    if ($urandom_range(0, 6) == 0)
      send_char(ss_pkg::REQ_PATTERN, pick_char(1'b1), 1'($urandom_range(0, 1)));
    items_sent += tlen + plen;
  endtask

  initial begin
    int job;
    int sel;
    int tlen;
    int plen;
    bit wide;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // pattern character while still loading text: dropped
    send_char(ss_pkg::REQ_PATTERN, 8'h78, 1'b1);
    // plain hit on the last text character
    chars = '{8'h61, 8'h62};
    send_string(ss_pkg::REQ_TEXT, chars, 1'b0);
    chars = '{8'h62};
    send_string(ss_pkg::REQ_PATTERN, chars, 1'b0);
    // pattern character after a finished job: dropped
    send_char(ss_pkg::REQ_PATTERN, 8'h62, 1'b1);
    // byte extremes, zero character stored like any other; a text character
    // sent between the text and the pattern is dropped
    chars = '{8'h00, 8'hFF, 8'h01};
    send_string(ss_pkg::REQ_TEXT, chars, 1'b0);
    send_char(ss_pkg::REQ_TEXT, 8'h7A, 1'b1);
    chars = '{8'hFF, 8'h01};
    send_string(ss_pkg::REQ_PATTERN, chars, 1'b0);
    // pattern longer than text: never found
    chars = '{8'h61};
    send_string(ss_pkg::REQ_TEXT, chars, 1'b0);
    chars = '{8'h61, 8'h62};
    send_string(ss_pkg::REQ_PATTERN, chars, 1'b0);
    // pattern equal to the whole text
    chars = '{8'h61, 8'h62, 8'h63};
    send_string(ss_pkg::REQ_TEXT, chars, 1'b0);
    send_string(ss_pkg::REQ_PATTERN, chars, 1'b0);
    // partial match that fails on the second character
    chars = '{8'h61, 8'h61, 8'h62};
    send_string(ss_pkg::REQ_TEXT, chars, 1'b0);
    chars = '{8'h61, 8'h63};
    send_string(ss_pkg::REQ_PATTERN, chars, 1'b0);

    // ---- random part ----
    // Mostly short jobs; some long ones, and a few that overflow either the
    // text or the pattern store. Two overflow jobs are always forced.
    for (job = 0; items_sent < JOB_ITEMS || job < MIN_JOBS; job++) begin
      idle_on = !(job >= 15 && job < 25);
      if (job == 10) wait_drained();
      wide = ($urandom_range(0, 7) == 0);
      sel  = $urandom_range(0, 99);
      if (job == 5) sel = 95;
      if (job == 12) sel = 99;
      if (sel < 88) begin
        tlen = $urandom_range(1, 12);
        plen = $urandom_range(1, tlen + 1);
      end else if (sel < 95) begin
        tlen = $urandom_range(13, MAX_LEN);
        plen = $urandom_range(1, 8);
      end else if (sel < 98) begin
        tlen = $urandom_range(MAX_LEN + 1, MAX_LEN + 12);
        plen = $urandom_range(1, 6);
      end else begin
        tlen = $urandom_range(1, MAX_LEN + 2);
        plen = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
      end
      run_job(tlen, plen, wide);
    end

    // ---- wrap up ----
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
